>>> rtl/core/mfb_pkg.sv
// package for the framebuffer blitter: constants, codes and control types
`default_nettype none

package mfb_pkg;

  localparam int unsigned WORDS_PER_ROW = 40;
  localparam int unsigned SCREEN_ROWS   = 400;
  localparam int unsigned WORD_BITS     = 16;

  localparam int unsigned FB_WORDS = WORDS_PER_ROW * SCREEN_ROWS;
  localparam int unsigned PIX_W    = WORDS_PER_ROW * WORD_BITS;
  localparam int unsigned ADDR_W   = $clog2(FB_WORDS + 1);
  localparam int unsigned X_W      = 10;
  localparam int unsigned Y_W      = 9;
  localparam int unsigned COL_W    = X_W - 4 + 1;
  localparam int unsigned ROW_W    = Y_W + 1;
  localparam int unsigned SUM_W    = Y_W + 2;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_FILL     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_OR_ROW   = 3'd4,
    OP_XOR_ROW  = 3'd5,
    OP_XNOR_ROW = 3'd6,
    OP_XOR_BYTE = 3'd7
  } op_e;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_CLIP   = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SETUP,
    CS_READ,
    CS_WRITE,
    CS_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic setup;
    logic rd;
    logic wr;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic work;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mfb_ctrl.sv
// controller state machine of the framebuffer blitter
`default_nettype none

module mfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfb_pkg::ctl_cmd_t cmd_o,
  input  mfb_pkg::dp_stat_t stat_i
);
  import mfb_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      CS_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_SETUP;
        end
      end
      CS_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.work ? CS_READ : CS_FINISH;
      end
      CS_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = CS_WRITE;
      end
      CS_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = stat_i.last ? CS_FINISH : CS_READ;
      end
      CS_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != CS_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/mfb_datapath.sv
// datapath of the framebuffer blitter: word registers, address walk and frame memory
`default_nettype none

module mfb_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfb_pkg::ctl_cmd_t cmd_i,
  output mfb_pkg::dp_stat_t stat_o,
  input  logic [2:0]        op_i,
  input  logic [9:0]        x_pos_i,
  input  logic [9:0]        x_end_i,
  input  logic [8:0]        y_pos_i,
  input  logic [8:0]        height_i,
  input  logic [15:0]       pattern_i,
  output logic [15:0]       read_data_o,
  output logic [1:0]        status_o
);
  import mfb_pkg::*;

  localparam logic [X_W-1:0] X_LAST = X_W'(PIX_W - 1);

  logic [WORD_BITS-1:0] mem_q [FB_WORDS];

  op_e                  op_q;
  logic [X_W-1:0]       x_q, xe_q;
  logic [Y_W-1:0]       y_q, h_q;
  logic [WORD_BITS-1:0] pat_q;
  logic [WORD_BITS-1:0] rd_q, rdata_q, read_data_q;
  logic [1:0]           st_q, status_q;
  logic [ROW_W-1:0]     row_q, row_last_q;
  logic [COL_W-1:0]     col_q, col_first_q, col_last_q;
  logic [ADDR_W-1:0]    base_q, clr_q;

  logic                 is_box;
  logic [COL_W-1:0]     w;
  logic [X_W-1:0]       xec;
  logic [SUM_W-1:0]     row_sum, row_end;
  logic                 s_work;
  logic [1:0]           s_status;
  logic [COL_W-1:0]     s_col_first, s_col_last;
  logic [ROW_W-1:0]     s_row_last;
  logic [WORD_BITS-1:0] pat_src;
  logic [2*WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] pv, fill_mask, clr_mask, new_word, wdata;
  logic [X_W-4:0]       byte_hi, byte_lo;
  logic [ADDR_W-1:0]    word_addr, mem_addr;
  logic                 mem_we, first_col, last_col;

  // setup decode
  always_comb begin
    is_box      = (op_q == OP_FILL) || (op_q == OP_CLEAR);
    w           = COL_W'(x_q[X_W-1:4]);
    xec         = (xe_q >= PIX_W) ? X_LAST : xe_q;
    row_sum     = SUM_W'(y_q) + SUM_W'(h_q);
    row_end     = (row_sum > SCREEN_ROWS) ? SUM_W'(SCREEN_ROWS) : row_sum;
    s_work      = 1'b0;
    s_status    = STAT_DONE;
    s_col_first = w;
    s_col_last  = w;
    s_row_last  = ROW_W'(y_q);
    case (op_q)
      OP_READ, OP_WRITE: begin
        s_work      = (x_q < WORDS_PER_ROW) && (y_q < SCREEN_ROWS);
        s_status    = s_work ? STAT_DONE : STAT_CLIP;
        s_col_first = COL_W'(x_q);
        s_col_last  = COL_W'(x_q);
      end
      OP_FILL, OP_CLEAR: begin
        s_col_last = COL_W'(xec[X_W-1:4]);
        s_row_last = ROW_W'(row_end - SUM_W'(1));
        if (xe_q < x_q) begin
          s_status = STAT_REJECT;
        end else if (h_q != '0) begin
          s_status = ((xe_q >= PIX_W) || (row_sum > SCREEN_ROWS)) ? STAT_CLIP : STAT_DONE;
          s_work   = (x_q < PIX_W) && (y_q < SCREEN_ROWS);
        end
      end
      default: begin
        s_work     = (y_q < SCREEN_ROWS) && (w < WORDS_PER_ROW);
        s_col_last = ((w + COL_W'(1)) < WORDS_PER_ROW) ? w + COL_W'(1) : w;
        if ((y_q >= SCREEN_ROWS) ||
            ((op_q == OP_XOR_BYTE) && ((x_q + 32'd8) > PIX_W)) ||
            ((op_q != OP_XOR_BYTE) && ((x_q + 32'd16) > PIX_W))) begin
          s_status = STAT_CLIP;
        end
      end
    endcase
  end

  // word update
  always_comb begin
    first_col = (col_q == col_first_q);
    last_col  = (col_q == col_last_q);
    case (op_q)
      OP_XNOR_ROW: pat_src = ~pat_q;
      OP_XOR_BYTE: pat_src = {pat_q[7:0], 8'h00};
      default:     pat_src = pat_q;
    endcase
    shifted   = {pat_src, 16'h0000} >> x_q[3:0];
    pv        = first_col ? shifted[31:16] : shifted[15:0];
    fill_mask = 16'hFFFF;
    if (first_col) fill_mask = fill_mask & (16'hFFFF >> x_q[3:0]);
    if (last_col)  fill_mask = fill_mask & (16'hFFFF << (4'd15 - xec[3:0]));
    byte_hi  = {col_q[COL_W-2:0], 1'b0};
    byte_lo  = {col_q[COL_W-2:0], 1'b1};
    clr_mask = {{8{(byte_hi >= x_q[X_W-1:3]) && (byte_hi <= xec[X_W-1:3])}},
                {8{(byte_lo >= x_q[X_W-1:3]) && (byte_lo <= xec[X_W-1:3])}}};
    case (op_q)
      OP_READ:   new_word = rdata_q;
      OP_WRITE:  new_word = pat_q;
      OP_FILL:   new_word = rdata_q | fill_mask;
      OP_CLEAR:  new_word = rdata_q & ~clr_mask;
      OP_OR_ROW: new_word = rdata_q | pv;
      default:   new_word = rdata_q ^ pv;
    endcase
  end

  assign word_addr = base_q + ADDR_W'(col_q);
  assign mem_addr  = cmd_i.clr_step ? clr_q : word_addr;
  assign mem_we    = cmd_i.clr_step || cmd_i.wr;
  assign wdata     = cmd_i.clr_step ? '0 : new_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(op_i);
      x_q   <= x_pos_i;
      xe_q  <= x_end_i;
      y_q   <= y_pos_i;
      h_q   <= height_i;
      pat_q <= pattern_i;
    end
    if (cmd_i.setup) begin
      rd_q        <= '0;
      st_q        <= s_status;
      row_q       <= ROW_W'(y_q);
      row_last_q  <= s_row_last;
      col_q       <= s_col_first;
      col_first_q <= s_col_first;
      col_last_q  <= s_col_last;
      base_q      <= ADDR_W'(y_q * WORDS_PER_ROW);
    end
    if (cmd_i.wr) begin
      if (!is_box && first_col) rd_q <= new_word;
      if (last_col) begin
        col_q  <= col_first_q;
        row_q  <= row_q + ROW_W'(1);
        base_q <= base_q + ADDR_W'(WORDS_PER_ROW);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
    if (cmd_i.out_load) begin
      read_data_q <= rd_q;
      status_q    <= st_q;
    end
  end

  assign stat_o.clr_last = (clr_q == ADDR_W'(FB_WORDS - 1));
  assign stat_o.work     = s_work;
  assign stat_o.last     = last_col && (row_q == row_last_q);

  assign read_data_o = read_data_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

>>> rtl/core/mono_framebuffer_blitter_top.sv
// top level of the monochrome framebuffer blitter
//
//   channel  signals                                           direction
//   in       in_valid_i, in_stall_o, op_i, x_pos_i, x_end_i,   into block
//            y_pos_i, height_i, pattern_i
//   out      out_valid_o, out_stall_i, read_data_o, status_o   out of block
//
// one word at a time: a setup state, then a read and a write per framebuffer word touched
// (read then write on the single memory port), next word taken once the result is loaded;
// a pattern row touches up to 2 words, a box one word per column per row,
// a rejected or off-screen word none
// after reset a clearing pass zeroes the frame memory, one word a cycle, all 16000 words,
// during which in_stall_o is high
// a waiting result sits in the output register while the next word is accepted
`default_nettype none

module mono_framebuffer_blitter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [9:0]  x_pos_i,
  input  logic [9:0]  x_end_i,
  input  logic [8:0]  y_pos_i,
  input  logic [8:0]  height_i,
  input  logic [15:0] pattern_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [1:0]  status_o
);
  import mfb_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mfb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .x_pos_i     (x_pos_i),
    .x_end_i     (x_end_i),
    .y_pos_i     (y_pos_i),
    .height_i    (height_i),
    .pattern_i   (pattern_i),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
// testbench for the monochrome framebuffer blitter with a framebuffer predictor
`timescale 1ns / 100ps

import mfb_pkg::*;

typedef struct packed {
  logic [15:0] data;
  logic [1:0]  status;
} blit_result_t;

class blit_scoreboard;
  logic [15:0]  frame [FB_WORDS];
  blit_result_t due_results [$];
  int unsigned  fails;

  function new();
    foreach (frame[i]) frame[i] = '0;
    fails = 0;
  endfunction

  function logic [1:0] place_row(input logic [15:0] pat, input int unsigned x, y, span,
                                 input bit use_xor, output logic [15:0] rd);
    logic [31:0] v;
    int unsigned w, a;
    logic [1:0]  st;
    st = STAT_DONE;
    rd = '0;
    if (y >= SCREEN_ROWS || x + span > PIX_W) st = STAT_CLIP;
    w = x >> 4;
    if (y < SCREEN_ROWS && w < WORDS_PER_ROW) begin
      v = {pat, 16'h0000} >> (x & 15);
      a = y * WORDS_PER_ROW + w;
      frame[a] = use_xor ? (frame[a] ^ v[31:16]) : (frame[a] | v[31:16]);
      if (w + 1 < WORDS_PER_ROW) begin
        frame[a + 1] = use_xor ? (frame[a + 1] ^ v[15:0]) : (frame[a + 1] | v[15:0]);
      end
      rd = frame[a];
    end
    return st;
  endfunction

  function logic [1:0] paint_box(input int unsigned x, xe, y, h, input bit byte_clear);
    int unsigned r, r_last, c, b, xl, a;
    logic [15:0] m;
    logic [1:0]  st;
    if (xe < x) return STAT_REJECT;
    if (h == 0) return STAT_DONE;
    st = (xe >= PIX_W || y + h > SCREEN_ROWS) ? STAT_CLIP : STAT_DONE;
    if (x >= PIX_W) return st;
    xl = (xe >= PIX_W) ? PIX_W - 1 : xe;
    r_last = (y + h > SCREEN_ROWS) ? SCREEN_ROWS : y + h;
    for (r = y; r < r_last; r++) begin
      if (byte_clear) begin
        for (b = x >> 3; b <= (xl >> 3); b++) begin
          a = r * WORDS_PER_ROW + (b >> 1);
          frame[a] = frame[a] & (b[0] ? 16'hFF00 : 16'h00FF);
        end
      end else begin
        for (c = x >> 4; c <= (xl >> 4); c++) begin
          m = 16'hFFFF;
          if (c == (x >> 4)) m = m & (16'hFFFF >> (x & 15));
          if (c == (xl >> 4)) m = m & (16'hFFFF << (15 - (xl & 15)));
          a = r * WORDS_PER_ROW + c;
          frame[a] = frame[a] | m;
        end
      end
    end
    return st;
  endfunction

  function void note_blit(input op_e op, input int unsigned x, xe, y, h,
                          input logic [15:0] pat);
    logic [15:0] rd;
    logic [1:0]  st;
    int unsigned a;
    rd = '0;
    st = STAT_DONE;
    case (op)
      OP_READ, OP_WRITE: begin
        if (x >= WORDS_PER_ROW || y >= SCREEN_ROWS) begin
          st = STAT_CLIP;
        end else begin
          a = y * WORDS_PER_ROW + x;
          if (op == OP_WRITE) frame[a] = pat;
          rd = frame[a];
        end
      end
      OP_FILL:     st = paint_box(x, xe, y, h, 1'b0);
      OP_CLEAR:    st = paint_box(x, xe, y, h, 1'b1);
      OP_OR_ROW:   st = place_row(pat, x, y, 16, 1'b0, rd);
      OP_XOR_ROW:  st = place_row(pat, x, y, 16, 1'b1, rd);
      OP_XNOR_ROW: st = place_row(~pat, x, y, 16, 1'b1, rd);
      default:     st = place_row({pat[7:0], 8'h00}, x, y, 8, 1'b1, rd);
    endcase
    due_results.push_back('{data: rd, status: st});
  endfunction

  task report_mismatch(input string what, input logic [15:0] got, want);
    fails++;
    $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
  endtask

  task check_result(input logic [15:0] data, input logic [1:0] status);
    blit_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with none outstanding", data, '0);
    end else begin
      want = due_results.pop_front();
      if (data !== want.data) report_mismatch("read_data", data, want.data);
      if (status !== want.status) report_mismatch("status", {14'h0, status}, {14'h0, want.status});
    end
  endtask
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [9:0]  x_pos_i;
  logic [9:0]  x_end_i;
  logic [8:0]  y_pos_i;
  logic [8:0]  height_i;
  logic [15:0] pattern_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] read_data_o;
  logic [1:0]  status_o;

  bit             calm;
  blit_scoreboard sb;

  mono_framebuffer_blitter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .x_pos_i     (x_pos_i),
    .x_end_i     (x_end_i),
    .y_pos_i     (y_pos_i),
    .height_i    (height_i),
    .pattern_i   (pattern_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(read_data_o, status_o);
  end

  // valid stays high after acceptance until the next word or an idle cycle replaces it
  task automatic send_word(input op_e op, input int unsigned x, xe, y, h,
                           input logic [15:0] pat);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    x_pos_i    <= x[9:0];
    x_end_i    <= xe[9:0];
    y_pos_i    <= y[8:0];
    height_i   <= h[8:0];
    pattern_i  <= pat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_blit(op, x, xe, y, h, pat);
  endtask

  initial begin
    int unsigned n, sel, x, xe, y, h;
    op_e         op;
    logic [15:0] pat;
    sb         = new();
    calm       = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = '0;
    x_pos_i    = '0;
    x_end_i    = '0;
    y_pos_i    = '0;
    height_i   = '0;
    pattern_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_READ,     0,    0,    0,   0,   16'h0000);
    send_word(OP_WRITE,    39,   0,    399, 0,   16'hFFFF);
    send_word(OP_WRITE,    0,    0,    0,   0,   16'hA5C3);
    send_word(OP_READ,     1023, 0,    0,   0,   16'h0000);
    send_word(OP_WRITE,    5,    0,    511, 0,   16'hFFFF);
    send_word(OP_OR_ROW,   0,    0,    1,   0,   16'h8001);
    send_word(OP_OR_ROW,   631,  0,    2,   0,   16'hFFFF);
    send_word(OP_XOR_ROW,  624,  0,    2,   0,   16'h0F0F);
    send_word(OP_XOR_ROW,  9,    0,    400, 0,   16'hFFFF);
    send_word(OP_XOR_ROW,  1023, 0,    3,   0,   16'hFFFF);
    send_word(OP_XNOR_ROW, 7,    0,    4,   0,   16'h0000);
    send_word(OP_XOR_BYTE, 636,  0,    5,   0,   16'h00FF);
    send_word(OP_XOR_BYTE, 11,   0,    5,   0,   16'hFF5A);
    send_word(OP_FILL,     3,    37,   6,   3,   16'h0000);
    send_word(OP_READ,     1,    0,    7,   0,   16'h0000);
    send_word(OP_FILL,     20,   19,   0,   5,   16'h0000);
    send_word(OP_FILL,     0,    639,  0,   0,   16'h0000);
    send_word(OP_FILL,     600,  1023, 398, 511, 16'h0000);
    send_word(OP_CLEAR,    5,    20,   6,   2,   16'h0000);
    send_word(OP_READ,     0,    0,    6,   0,   16'h0000);
    send_word(OP_CLEAR,    640,  700,  0,   1,   16'h0000);
    send_word(OP_CLEAR,    9,    3,    0,   1,   16'h0000);
    send_word(OP_FILL,     0,    639,  0,   400, 16'h0000);
    send_word(OP_READ,     39,   0,    399, 0,   16'h0000);
    send_word(OP_CLEAR,    0,    639,  0,   400, 16'h0000);
    send_word(OP_READ,     20,   0,    200, 0,   16'h0000);

    for (n = 0; n < 650; n++) begin
      calm = (n >= 250 && n < 400);
      if (n == 500) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.due_results.size() != 0);
      end
      sel = $urandom_range(0, 99);
      op = op_e'(sel < 25 ? OP_READ : sel < 35 ? OP_WRITE : sel < 45 ? OP_FILL :
                 sel < 53 ? OP_CLEAR : sel < 65 ? OP_OR_ROW : sel < 77 ? OP_XOR_ROW :
                 sel < 87 ? OP_XNOR_ROW : OP_XOR_BYTE);
      sel = $urandom_range(0, 99);
      y = sel < 40 ? $urandom_range(0, 5) : sel < 80 ? $urandom_range(394, 399) :
          sel < 92 ? $urandom_range(0, 399) : $urandom_range(0, 511);
      pat = $urandom_range(0, 65535);
      xe  = $urandom_range(0, 1023);
      h   = $urandom_range(0, 511);
      case (op)
        OP_READ, OP_WRITE: begin
          x = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 39) : $urandom_range(0, 1023);
        end
        OP_FILL, OP_CLEAR: begin
          x = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 639) : $urandom_range(0, 1023);
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            xe = x + $urandom_range(0, 48);
            if (xe > 1023) xe = 1023;
          end else if (sel < 85) begin
            xe = (x == 0) ? 0 : $urandom_range(0, x - 1);
          end else begin
            xe = $urandom_range(x, 1023);
          end
          sel = $urandom_range(0, 99);
          if (sel < 75) begin
            h = $urandom_range(0, 4);
          end else if (sel < 90) begin
            h = $urandom_range(0, 12);
          end else begin
            // tall boxes only near the bottom so the clipped height stays short
            y = $urandom_range(380, 511);
            h = $urandom_range(0, 511);
          end
        end
        default: begin
          sel = $urandom_range(0, 99);
          x = sel < 75 ? $urandom_range(0, 639) : sel < 90 ? $urandom_range(600, 639) :
              $urandom_range(0, 1023);
        end
      endcase
      send_word(op, x, xe, y, h, pat);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (sb.due_results.size() != 0);
    repeat (40) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
